[rtl/core/rwcp_pkg.sv]
// Shared constants and types for the RIFF/WAVE chunk parser.
// Used by riff_wave_chunk_parser and rwcp_div; depends on nothing.
package rwcp_pkg;

   // Chunk ids, little-endian four-character codes
   localparam logic [31:0] ID_RIFF = 32'h4646_4952;
   localparam logic [31:0] ID_WAVE = 32'h4556_4157;
   localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
   localparam logic [31:0] ID_DATA = 32'h6174_6164;
   localparam logic [31:0] ID_FACT = 32'h7463_6166;

   // Result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_RIFF  = 3'd1;
   localparam logic [2:0] ST_NOT_WAVE  = 3'd2;
   localparam logic [2:0] ST_COMPRESS  = 3'd3;
   localparam logic [2:0] ST_SIZE_BAD  = 3'd4;
   localparam logic [2:0] ST_NO_DATA   = 3'd5;
   localparam logic [2:0] ST_ZERO_RATE = 3'd6;

   localparam int WORD_BYTES = 4;
   localparam int FMT_BYTES  = 16;

   // Duration: length * 1000 / byte rate
   localparam int          LEN_W     = 32;
   localparam int          MS_W      = 10;
   localparam logic [MS_W-1:0] MS_PER_S = 10'd1000;
   localparam int          DIVIDEND_W = LEN_W + MS_W;
   localparam int          DIVISOR_W  = 32;

   typedef logic [FMT_BYTES-1:0][7:0] fmt_bytes_type;

endpackage

[rtl/core/rwcp_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Widths default from rwcp_pkg; divisor must be nonzero when started.
module rwcp_div #(
   parameter int DIVIDEND_W = rwcp_pkg::DIVIDEND_W,
   parameter int DIVISOR_W  = rwcp_pkg::DIVISOR_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dsr_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [DIVISOR_W:0]    rem_shift;
   logic                  ge;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};
      ge        = rem_shift >= {1'b0, dsr_ff};
      rem_in    = ge ? DIVISOR_W'(rem_shift - {1'b0, dsr_ff}) : rem_shift[DIVISOR_W-1:0];
      quo_in    = {quo_ff[DIVIDEND_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= '0;
            quo_ff  <= dividend;
            dsr_ff  <= divisor;
            cnt_ff  <= CNT_W'(DIVIDEND_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/core/riff_wave_chunk_parser.sv]
// RIFF/WAVE chunk parser: byte-serial chunk walker with data pass-through.
// Depends on rwcp_pkg and rwcp_div (duration divider).
//
//   channel  direction  handshake             word
//   req      in         req_valid/req_stall    one file byte, start-of-file flag
//   rsp      out        rsp_valid/rsp_stall    data byte and/or final file status
//   csr      in         csr_valid/csr_ready    expected data chunk size
//
// A new file byte is taken whenever no division runs and the result register is free.
// The byte that ends a data chunk with a nonzero byte rate starts a duration division:
// a 32x10 multiply, then the divider producing one quotient bit a cycle.
// req_stall is high during that division and while rsp holds a stalled word.
// Reset is synchronous and clears the parser and the expected size to zero.
// A start-of-file byte restarts the parser; the expected size is kept.
module riff_wave_chunk_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_value,
   input  logic        req_start_of_file,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_payload_valid,
   output logic        rsp_done_res,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_data_length,
   output logic [31:0] rsp_duration_ms,
   output logic [15:0] rsp_format_tag,
   output logic [15:0] rsp_channel_count,
   output logic [31:0] rsp_sample_rate,
   output logic [31:0] rsp_byte_rate,
   output logic [15:0] rsp_block_align,
   output logic [15:0] rsp_bits_per_sample,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_expected_data_size
);

   typedef enum logic [2:0] {
      PH_RIFF, PH_RLEN, PH_WAVE, PH_ID, PH_CLEN, PH_BODY, PH_PAD
   } phase_type;

   typedef enum logic [1:0] {
      CTL_RUN, CTL_DIV_LOAD, CTL_DIV_WAIT
   } ctl_type;

   // Parser state
   phase_type               phase_ff, phase_in, cur_phase;
   logic                    finished_ff, finished_in, cur_finished;
   logic [31:0]             count_ff, count_in, cur_count;
   logic [31:0]             chunk_id_ff, chunk_id_in, cur_id;
   logic [31:0]             chunk_len_ff, chunk_len_in, cur_len;
   logic [32:0]             consumed_ff, consumed_in, cur_consumed;
   logic [31:0]             limit_ff, limit_in, cur_limit;
   rwcp_pkg::fmt_bytes_type fmt_ff, fmt_in, cur_fmt;
   logic [31:0]             expected_ff;

   // Step helpers
   logic        sof;
   logic [31:0] cnt_inc;
   logic        gfull;
   logic [31:0] id_gath, len_gath;
   logic [32:0] consumed_inc;
   logic        at_limit;
   logic [31:0] cur_rate;

   // Step result
   logic        res_valid, res_need_div, res_pay_valid, res_done;
   logic [7:0]  res_pay_byte;
   logic [2:0]  res_status;
   logic [31:0] res_len;

   // Sequencer and output register
   ctl_type                 ctl_ff;
   logic [7:0]              pend_byte_ff;
   logic                    pend_valid_ff;
   logic                    rsp_valid_ff;
   logic [7:0]              out_byte_ff;
   logic                    out_pay_valid_ff;
   logic                    out_done_ff;
   logic [2:0]              out_status_ff;
   logic [31:0]             out_len_ff;
   logic [31:0]             out_dur_ff;
   rwcp_pkg::fmt_bytes_type out_fmt_ff;

   logic                              accept;
   logic                              div_start;
   logic                              div_done;
   logic [rwcp_pkg::DIVIDEND_W-1:0]   div_dividend;
   logic [rwcp_pkg::DIVIDEND_W-1:0]   div_quotient;
   logic [31:0]                       dur_sat;

   // Place one byte into its lane of a little-endian word being collected
   function automatic logic [31:0] gather_word(input logic [31:0] word,
                                               input logic [1:0]  pos,
                                               input logic [7:0]  b);
      logic [31:0] w;
      w = word;
      case (pos)
         2'd0:    w = {24'd0, b};
         2'd1:    w[15:8] = b;
         2'd2:    w[23:16] = b;
         2'd3:    w[31:24] = b;
         default: w = word;
      endcase
      return w;
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = (ctl_ff != CTL_RUN) || (rsp_valid_ff && rsp_stall);
   assign csr_ready = 1'b1;

   // Parser step for the byte on req, after a restart if flagged
   always_comb begin
      sof          = req_start_of_file;
      cur_phase    = sof ? PH_RIFF : phase_ff;
      cur_finished = sof ? 1'b0 : finished_ff;
      cur_count    = sof ? 32'd0 : count_ff;
      cur_id       = sof ? 32'd0 : chunk_id_ff;
      cur_len      = sof ? 32'd0 : chunk_len_ff;
      cur_consumed = sof ? 33'd0 : consumed_ff;
      cur_limit    = sof ? 32'd0 : limit_ff;
      cur_fmt      = sof ? '0 : fmt_ff;

      cnt_inc      = cur_count + 32'd1;
      gfull        = cur_count[1:0] == 2'd3;
      id_gath      = gather_word(cur_id, cur_count[1:0], req_byte_value);
      len_gath     = gather_word(cur_len, cur_count[1:0], req_byte_value);
      consumed_inc = cur_consumed + {32'd0, ~(&cur_consumed)};
      at_limit     = consumed_inc >= {1'b0, cur_limit};
      cur_rate     = {cur_fmt[11], cur_fmt[10], cur_fmt[9], cur_fmt[8]};

      phase_in     = cur_phase;
      finished_in  = cur_finished;
      count_in     = cur_count;
      chunk_id_in  = cur_id;
      chunk_len_in = cur_len;
      consumed_in  = cur_consumed;
      limit_in     = cur_limit;
      fmt_in       = cur_fmt;

      res_valid     = 1'b0;
      res_need_div  = 1'b0;
      res_pay_valid = 1'b0;
      res_pay_byte  = 8'd0;
      res_done      = 1'b0;
      res_status    = rwcp_pkg::ST_OK;
      res_len       = 32'd0;

      if (!cur_finished) begin
         case (cur_phase)
            PH_RIFF: begin
               chunk_id_in = id_gath;
               count_in    = gfull ? 32'd0 : cnt_inc;
               if (gfull) begin
                  if (id_gath != rwcp_pkg::ID_RIFF) begin
                     finished_in = 1'b1;
                     res_valid   = 1'b1;
                     res_done    = 1'b1;
                     res_status  = rwcp_pkg::ST_NOT_RIFF;
                  end else begin
                     phase_in = PH_RLEN;
                  end
               end
            end
            PH_RLEN: begin
               chunk_len_in = len_gath;
               count_in     = gfull ? 32'd0 : cnt_inc;
               if (gfull) begin
                  limit_in = (len_gath >= 32'(rwcp_pkg::WORD_BYTES))
                           ? len_gath - 32'(rwcp_pkg::WORD_BYTES) : 32'd0;
                  phase_in = PH_WAVE;
               end
            end
            PH_WAVE: begin
               chunk_id_in = id_gath;
               count_in    = gfull ? 32'd0 : cnt_inc;
               if (gfull) begin
                  if (id_gath != rwcp_pkg::ID_WAVE) begin
                     finished_in = 1'b1;
                     res_valid   = 1'b1;
                     res_done    = 1'b1;
                     res_status  = rwcp_pkg::ST_NOT_WAVE;
                  end else if (cur_limit == 32'd0) begin
                     finished_in = 1'b1;
                     res_valid   = 1'b1;
                     res_done    = 1'b1;
                     res_status  = rwcp_pkg::ST_NO_DATA;
                  end else begin
                     phase_in = PH_ID;
                  end
               end
            end
            PH_ID: begin
               consumed_in = consumed_inc;
               chunk_id_in = id_gath;
               count_in    = gfull ? 32'd0 : cnt_inc;
               if (gfull) begin
                  if (id_gath == rwcp_pkg::ID_FACT) begin
                     finished_in = 1'b1;
                     res_valid   = 1'b1;
                     res_done    = 1'b1;
                     res_status  = rwcp_pkg::ST_COMPRESS;
                  end else begin
                     phase_in = PH_CLEN;
                  end
               end
            end
            PH_CLEN: begin
               consumed_in  = consumed_inc;
               chunk_len_in = len_gath;
               count_in     = gfull ? 32'd0 : cnt_inc;
               if (gfull) begin
                  if (cur_id == rwcp_pkg::ID_DATA) begin
                     if (len_gath != expected_ff) begin
                        finished_in = 1'b1;
                        res_valid   = 1'b1;
                        res_done    = 1'b1;
                        res_status  = rwcp_pkg::ST_SIZE_BAD;
                        res_len     = len_gath;
                     end else if (len_gath == 32'd0) begin
                        // Empty data chunk: finish without a payload byte
                        finished_in  = 1'b1;
                        res_valid    = 1'b1;
                        res_done     = 1'b1;
                        res_len      = len_gath;
                        res_need_div = cur_rate != 32'd0;
                        res_status   = (cur_rate == 32'd0)
                                     ? rwcp_pkg::ST_ZERO_RATE : rwcp_pkg::ST_OK;
                     end else begin
                        phase_in = PH_BODY;
                     end
                  end else if (len_gath == 32'd0) begin
                     // Empty chunk: length is even, go straight to the limit check
                     if (at_limit) begin
                        finished_in = 1'b1;
                        res_valid   = 1'b1;
                        res_done    = 1'b1;
                        res_status  = rwcp_pkg::ST_NO_DATA;
                     end else begin
                        phase_in = PH_ID;
                     end
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               consumed_in = consumed_inc;
               count_in    = cnt_inc;
               if (cur_id == rwcp_pkg::ID_FMT && cur_count[31:4] == 28'd0) begin
                  fmt_in[cur_count[3:0]] = req_byte_value;
               end
               if (cur_id == rwcp_pkg::ID_DATA) begin
                  res_valid     = 1'b1;
                  res_pay_valid = 1'b1;
                  res_pay_byte  = req_byte_value;
                  if (cnt_inc >= cur_len) begin
                     finished_in  = 1'b1;
                     res_done     = 1'b1;
                     res_len      = cur_len;
                     res_need_div = cur_rate != 32'd0;
                     res_status   = (cur_rate == 32'd0)
                                  ? rwcp_pkg::ST_ZERO_RATE : rwcp_pkg::ST_OK;
                  end
               end else if (cnt_inc >= cur_len) begin
                  count_in = 32'd0;
                  if (cur_len[0]) begin
                     phase_in = PH_PAD;
                  end else if (at_limit) begin
                     finished_in = 1'b1;
                     res_valid   = 1'b1;
                     res_done    = 1'b1;
                     res_status  = rwcp_pkg::ST_NO_DATA;
                  end else begin
                     phase_in = PH_ID;
                  end
               end
            end
            PH_PAD: begin
               consumed_in = consumed_inc;
               count_in    = 32'd0;
               if (at_limit) begin
                  finished_in = 1'b1;
                  res_valid   = 1'b1;
                  res_done    = 1'b1;
                  res_status  = rwcp_pkg::ST_NO_DATA;
               end else begin
                  phase_in = PH_ID;
               end
            end
            default: begin
               phase_in = PH_RIFF;
            end
         endcase
      end
   end

   // Duration divider operands and saturation
   assign div_start    = ctl_ff == CTL_DIV_LOAD;
   assign div_dividend = {{rwcp_pkg::MS_W{1'b0}}, chunk_len_ff}
                       * {{rwcp_pkg::LEN_W{1'b0}}, rwcp_pkg::MS_PER_S};
   assign dur_sat      = (|div_quotient[rwcp_pkg::DIVIDEND_W-1:rwcp_pkg::LEN_W])
                       ? 32'hFFFF_FFFF : div_quotient[rwcp_pkg::LEN_W-1:0];

   rwcp_div #(
      .DIVIDEND_W (rwcp_pkg::DIVIDEND_W),
      .DIVISOR_W  (rwcp_pkg::DIVISOR_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  ({fmt_ff[11], fmt_ff[10], fmt_ff[9], fmt_ff[8]}),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_RIFF;
         finished_ff   <= 1'b0;
         count_ff      <= 32'd0;
         chunk_id_ff   <= 32'd0;
         chunk_len_ff  <= 32'd0;
         consumed_ff   <= 33'd0;
         limit_ff      <= 32'd0;
         fmt_ff        <= '0;
         expected_ff   <= 32'd0;
         ctl_ff        <= CTL_RUN;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // Take a configuration write
         if (csr_valid && csr_ready) begin
            expected_ff <= csr_expected_data_size;
         end

         // Advance the parser on each accepted byte
         if (accept) begin
            phase_ff     <= phase_in;
            finished_ff  <= finished_in;
            count_ff     <= count_in;
            chunk_id_ff  <= chunk_id_in;
            chunk_len_ff <= chunk_len_in;
            consumed_ff  <= consumed_in;
            limit_ff     <= limit_in;
            fmt_ff       <= fmt_in;
         end

         // Drain the output word once taken
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (ctl_ff)
            CTL_RUN: begin
               if (accept && res_need_div) begin
                  pend_byte_ff  <= res_pay_byte;
                  pend_valid_ff <= res_pay_valid;
                  ctl_ff        <= CTL_DIV_LOAD;
               end else if (accept && res_valid) begin
                  rsp_valid_ff     <= 1'b1;
                  out_byte_ff      <= res_pay_byte;
                  out_pay_valid_ff <= res_pay_valid;
                  out_done_ff      <= res_done;
                  out_status_ff    <= res_status;
                  out_len_ff       <= res_len;
                  out_dur_ff       <= 32'd0;
                  out_fmt_ff       <= res_done ? fmt_in : '0;
               end
            end
            CTL_DIV_LOAD: begin
               ctl_ff <= CTL_DIV_WAIT;
            end
            CTL_DIV_WAIT: begin
               // Hold until the quotient is in, then post the final word
               if (div_done) begin
                  ctl_ff           <= CTL_RUN;
                  rsp_valid_ff     <= 1'b1;
                  out_byte_ff      <= pend_byte_ff;
                  out_pay_valid_ff <= pend_valid_ff;
                  out_done_ff      <= 1'b1;
                  out_status_ff    <= rwcp_pkg::ST_OK;
                  out_len_ff       <= chunk_len_ff;
                  out_dur_ff       <= dur_sat;
                  out_fmt_ff       <= fmt_ff;
               end
            end
            default: begin
               ctl_ff <= CTL_RUN;
            end
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_payload_byte    = out_byte_ff;
   assign rsp_payload_valid   = out_pay_valid_ff;
   assign rsp_done_res        = out_done_ff;
   assign rsp_status          = out_status_ff;
   assign rsp_data_length     = out_len_ff;
   assign rsp_duration_ms     = out_dur_ff;
   assign rsp_format_tag      = {out_fmt_ff[1], out_fmt_ff[0]};
   assign rsp_channel_count   = {out_fmt_ff[3], out_fmt_ff[2]};
   assign rsp_sample_rate     = {out_fmt_ff[7], out_fmt_ff[6], out_fmt_ff[5], out_fmt_ff[4]};
   assign rsp_byte_rate       = {out_fmt_ff[11], out_fmt_ff[10], out_fmt_ff[9], out_fmt_ff[8]};
   assign rsp_block_align     = {out_fmt_ff[13], out_fmt_ff[12]};
   assign rsp_bits_per_sample = {out_fmt_ff[15], out_fmt_ff[14]};

   // Divider finishes only while the sequencer waits for it
   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> ctl_ff == CTL_DIV_WAIT)
      else $error("divider done outside wait state");

   // No byte is taken while a division is in flight
   a_no_accept_in_div: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff != CTL_RUN) |-> !accept)
      else $error("byte accepted during division");

   // A posted final word means the parser has finished its file
   a_done_means_finished: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_done_ff) |-> finished_ff)
      else $error("final word posted while parser still running");

   // A good finish comes with the last data byte or an empty data chunk
   a_ok_has_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_done_ff && out_status_ff == rwcp_pkg::ST_OK)
         |-> (out_pay_valid_ff || out_len_ff == 32'd0))
      else $error("good finish without data byte on a nonempty chunk");

   // Non-payload words carry a zero byte
   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !out_pay_valid_ff) |-> out_byte_ff == 8'd0)
      else $error("payload byte set without payload valid");

endmodule

[tb/tb_riff_wave_chunk_parser.sv]
// Self-checking testbench for riff_wave_chunk_parser: RIFF/WAVE byte streams in,
// data bytes and per-file status words out, checked against a built-in parser model.
// Depends on rwcp_pkg and the riff_wave_chunk_parser RTL only.
module tb_riff_wave_chunk_parser;
   timeunit 1ns;
   timeprecision 1ps;

   import rwcp_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 400_000;
   localparam int unsigned SETTLE_CYCLES = 60;
   localparam int unsigned PHASE_BYTES   = 125;
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned MAX_REPORTS   = 40;

   typedef enum logic [2:0] {
      PH_RIFF, PH_RLEN, PH_WAVE, PH_ID, PH_CLEN, PH_BODY, PH_PAD
   } walk_phase_t;

   typedef struct packed {
      logic [7:0] value;
      logic       sof;
   } file_word_t;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        payload_valid;
      logic        done_res;
      logic [2:0]  status;
      logic [31:0] data_length;
      logic [31:0] duration_ms;
      logic [15:0] format_tag;
      logic [15:0] channel_count;
      logic [31:0] sample_rate;
      logic [31:0] byte_rate;
      logic [15:0] block_align;
      logic [15:0] bits_per_sample;
   } rsp_word_t;

   // DUT ports, inputs all known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_byte_value = '0;
   logic        req_start_of_file = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_payload_valid;
   logic        rsp_done_res;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_data_length;
   logic [31:0] rsp_duration_ms;
   logic [15:0] rsp_format_tag;
   logic [15:0] rsp_channel_count;
   logic [31:0] rsp_sample_rate;
   logic [31:0] rsp_byte_rate;
   logic [15:0] rsp_block_align;
   logic [15:0] rsp_bits_per_sample;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_expected_data_size = '0;

   // Parser model state
   walk_phase_t   walk_phase;
   logic [31:0]   field_count;
   logic [31:0]   cur_id;
   logic [31:0]   cur_len;
   logic [32:0]   bytes_after_wave;
   logic [32:0]   byte_budget;
   fmt_bytes_type fmt_store;
   logic          file_closed;
   logic [31:0]   size_setting = '0;

   // Bench bookkeeping
   file_word_t  file_bytes[$];
   rsp_word_t   awaited_words[$];
   logic        byte_accepted = 1'b0;
   int unsigned queued_count = 0;
   int unsigned accepted_count = 0;
   int unsigned error_count = 0;
   int unsigned result_words = 0;
   int unsigned payload_words = 0;
   int unsigned size_writes = 0;
   int unsigned status_seen[8];
   int unsigned send_idle_pct = 26;
   int unsigned recv_idle_pct = 69;
   int unsigned hold_left = 0;
   int unsigned cycle_count = 0;

   riff_wave_chunk_parser u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_byte_value         (req_byte_value),
      .req_start_of_file      (req_start_of_file),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_payload_byte       (rsp_payload_byte),
      .rsp_payload_valid      (rsp_payload_valid),
      .rsp_done_res           (rsp_done_res),
      .rsp_status             (rsp_status),
      .rsp_data_length        (rsp_data_length),
      .rsp_duration_ms        (rsp_duration_ms),
      .rsp_format_tag         (rsp_format_tag),
      .rsp_channel_count      (rsp_channel_count),
      .rsp_sample_rate        (rsp_sample_rate),
      .rsp_byte_rate          (rsp_byte_rate),
      .rsp_block_align        (rsp_block_align),
      .rsp_bits_per_sample    (rsp_bits_per_sample),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_expected_data_size (csr_expected_data_size)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // ---------------------------------------------------------------
   // Parser model
   // ---------------------------------------------------------------

   function automatic void clear_walk();
      walk_phase       = PH_RIFF;
      field_count      = '0;
      cur_id           = '0;
      cur_len          = '0;
      bytes_after_wave = '0;
      byte_budget      = '0;
      fmt_store        = '0;
      file_closed      = 1'b0;
   endfunction

   // Count bytes past the WAVE magic, saturating at 33 bits
   function automatic void tally_byte();
      if (bytes_after_wave != 33'h1_FFFF_FFFF) bytes_after_wave++;
   endfunction

   // Shift one little-endian byte into acc; true once four are in
   function automatic logic take_le_byte(inout logic [31:0] acc, input logic [7:0] b);
      if (field_count == '0) acc = '0;
      acc[8*field_count[1:0] +: 8] = b;
      field_count++;
      if (field_count >= WORD_BYTES) begin
         field_count = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void close_file(inout rsp_word_t w, input logic [2:0] st,
                                      input logic [31:0] len, input logic [31:0] dur);
      file_closed       = 1'b1;
      w.done_res        = 1'b1;
      w.status          = st;
      w.data_length     = len;
      w.duration_ms     = dur;
      w.format_tag      = fmt_store[1:0];
      w.channel_count   = fmt_store[3:2];
      w.sample_rate     = fmt_store[7:4];
      w.byte_rate       = fmt_store[11:8];
      w.block_align     = fmt_store[13:12];
      w.bits_per_sample = fmt_store[15:14];
   endfunction

   // End of the data chunk: duration from byte rate, saturated to 32 bits
   function automatic void close_data(inout rsp_word_t w);
      logic [31:0] rate;
      logic [63:0] quot;
      rate = fmt_store[11:8];
      if (rate == '0) begin
         close_file(w, ST_ZERO_RATE, cur_len, '0);
      end else begin
         quot = (64'(cur_len) * 64'(MS_PER_S)) / 64'(rate);
         if (quot > 64'hFFFF_FFFF) quot = 64'hFFFF_FFFF;
         close_file(w, ST_OK, cur_len, quot[31:0]);
      end
   endfunction

   // After a non-data chunk: take the pad byte if the length is odd, then check the RIFF budget
   function automatic logic end_chunk(inout rsp_word_t w, input logic pad_done);
      field_count = '0;
      if (!pad_done && cur_len[0]) begin
         walk_phase = PH_PAD;
         return 1'b0;
      end
      if (bytes_after_wave >= byte_budget) begin
         close_file(w, ST_NO_DATA, '0, '0);
         return 1'b1;
      end
      walk_phase = PH_ID;
      return 1'b0;
   endfunction

   // Advance the model by one file byte; true when it yields a result word
   function automatic logic parse_file_byte(input logic [7:0] b, input logic sof,
                                            output rsp_word_t w);
      w = '0;
      if (sof) clear_walk();
      if (file_closed) return 1'b0;
      case (walk_phase)
         PH_RIFF: begin
            if (take_le_byte(cur_id, b)) begin
               if (cur_id != ID_RIFF) begin
                  close_file(w, ST_NOT_RIFF, '0, '0);
                  return 1'b1;
               end
               walk_phase = PH_RLEN;
            end
         end
         PH_RLEN: begin
            if (take_le_byte(cur_len, b)) begin
               byte_budget = (cur_len >= WORD_BYTES) ? 33'(cur_len) - 33'(WORD_BYTES) : '0;
               walk_phase  = PH_WAVE;
            end
         end
         PH_WAVE: begin
            if (take_le_byte(cur_id, b)) begin
               if (cur_id != ID_WAVE) begin
                  close_file(w, ST_NOT_WAVE, '0, '0);
                  return 1'b1;
               end
               if (byte_budget == '0) begin
                  close_file(w, ST_NO_DATA, '0, '0);
                  return 1'b1;
               end
               walk_phase = PH_ID;
            end
         end
         PH_ID: begin
            tally_byte();
            if (take_le_byte(cur_id, b)) begin
               if (cur_id == ID_FACT) begin
                  close_file(w, ST_COMPRESS, '0, '0);
                  return 1'b1;
               end
               walk_phase = PH_CLEN;
            end
         end
         PH_CLEN: begin
            tally_byte();
            if (take_le_byte(cur_len, b)) begin
               if (cur_id == ID_DATA) begin
                  if (cur_len != size_setting) begin
                     close_file(w, ST_SIZE_BAD, cur_len, '0);
                     return 1'b1;
                  end
                  if (cur_len == '0) begin
                     close_data(w);
                     return 1'b1;
                  end
                  walk_phase = PH_BODY;
               end else if (cur_len == '0) begin
                  return end_chunk(w, 1'b0);
               end else begin
                  walk_phase = PH_BODY;
               end
            end
         end
         PH_BODY: begin
            tally_byte();
            if (cur_id == ID_FMT && field_count < FMT_BYTES) fmt_store[field_count[3:0]] = b;
            field_count++;
            if (cur_id == ID_DATA) begin
               w.payload_byte  = b;
               w.payload_valid = 1'b1;
               if (field_count >= cur_len) close_data(w);
               return 1'b1;
            end
            if (field_count >= cur_len) return end_chunk(w, 1'b0);
         end
         PH_PAD: begin
            tally_byte();
            return end_chunk(w, 1'b1);
         end
         default: walk_phase = PH_RIFF;
      endcase
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------

   function automatic void put_word(ref logic [7:0] q[$], input logic [31:0] v);
      for (int i = 0; i < 4; i++) q.push_back(v[8*i +: 8]);
   endfunction

   function automatic logic [31:0] pick_rate();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) return '0;
      if (roll < 40) return $urandom_range(1, 300);
      if (roll < 70) return $urandom;
      return 32'd4 * $urandom_range(8000, 48000);
   endfunction

   // fmt chunk: mostly 16 bytes, sometimes short, sometimes long; odd lengths get a pad byte
   function automatic void put_fmt(ref logic [7:0] q[$], input logic [31:0] rate);
      fmt_bytes_type f;
      int unsigned   len;
      int unsigned   roll;
      roll = $urandom_range(0, 9);
      len  = (roll < 7) ? 16 : (roll == 7) ? $urandom_range(17, 21) : $urandom_range(0, 15);
      f[1:0]   = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd1;
      f[3:2]   = 16'($urandom_range(1, 8));
      f[7:4]   = $urandom;
      f[11:8]  = rate;
      f[13:12] = 16'($urandom_range(1, 16));
      f[15:14] = $urandom_range(0, 1) ? 16'd16 : 16'($urandom);
      put_word(q, ID_FMT);
      put_word(q, len);
      for (int i = 0; i < len; i++) q.push_back((i < FMT_BYTES) ? f[i] : 8'($urandom));
      if (len % 2) q.push_back(8'($urandom));
   endfunction

   // Extra chunk ahead of the data: a repeated fmt or an unknown chunk
   function automatic void put_other(ref logic [7:0] q[$]);
      int unsigned len;
      if ($urandom_range(0, 3) == 0) begin
         put_fmt(q, pick_rate());
      end else begin
         len = $urandom_range(0, 7);
         put_word(q, $urandom);
         put_word(q, len);
         repeat (len) q.push_back(8'($urandom));
         if (len % 2) q.push_back(8'($urandom));
      end
   endfunction

   task automatic queue_bytes(input logic [7:0] seq[$], input int unsigned count);
      file_word_t fw;
      for (int i = 0; i < count; i++) begin
         fw.value = seq[i];
         fw.sof   = (i == 0);
         file_bytes.push_back(fw);
         queued_count++;
      end
   endtask

   task automatic queue_noise();
      file_word_t fw;
      repeat ($urandom_range(1, 8)) begin
         fw.value = 8'($urandom);
         fw.sof   = ($urandom_range(0, 5) == 0);
         file_bytes.push_back(fw);
         queued_count++;
      end
   endtask

   // Build one file: mostly well formed, sometimes broken or cut off
   task automatic queue_wave_file(input logic [31:0] data_size);
      logic [7:0]  chunks[$];
      logic [7:0]  whole[$];
      logic [31:0] riff_len;
      logic [31:0] dlen;
      int unsigned roll;
      int unsigned keep_len;
      if ($urandom_range(0, 9) != 0) put_fmt(chunks, pick_rate());
      repeat ($urandom_range(0, 2)) put_other(chunks);
      if ($urandom_range(0, 19) == 0) begin
         put_word(chunks, ID_FACT);
         put_word(chunks, $urandom_range(0, 8));
      end
      // data chunk: matching, mismatched or missing
      roll = $urandom_range(0, 99);
      if (roll >= 6) begin
         dlen = (roll < 16) ? data_size ^ (32'd1 << $urandom_range(0, 31)) : data_size;
         put_word(chunks, ID_DATA);
         put_word(chunks, dlen);
         if (dlen == data_size) begin
            if (dlen > 64) repeat ($urandom_range(1, 20)) chunks.push_back(8'($urandom));
            else repeat (dlen) chunks.push_back(8'($urandom));
         end
      end
      roll = $urandom_range(0, 99);
      if (roll < 80) riff_len = 4 + chunks.size();
      else if (roll < 87) riff_len = $urandom_range(0, 7);
      else if (roll < 94) riff_len = 4 + $urandom_range(0, chunks.size());
      else riff_len = $urandom;
      put_word(whole, ($urandom_range(0, 24) == 0) ?
               ID_RIFF ^ (32'd1 << $urandom_range(0, 31)) : ID_RIFF);
      put_word(whole, riff_len);
      put_word(whole, ($urandom_range(0, 24) == 0) ?
               ID_WAVE ^ (32'd1 << $urandom_range(0, 31)) : ID_WAVE);
      whole = {whole, chunks};
      keep_len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, whole.size()) : whole.size();
      queue_bytes(whole, keep_len);
   endtask

   // ---------------------------------------------------------------
   // Driver, receiver and monitor
   // ---------------------------------------------------------------

   // Offer the next file byte; hold it while stalled
   always @(negedge clock) begin : drive_bytes
      file_word_t nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || byte_accepted) begin
         if (file_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = file_bytes.pop_front();
            req_valid         <= 1'b1;
            req_byte_value    <= nxt.value;
            req_start_of_file <= nxt.sof;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall the result channel at random, or for a long hold when asked
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] seen);
      if (seen !== want) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t ns %s: expected 0x%0h, actual 0x%0h", $time, name, want, seen);
      end
   endfunction

   // Predict on each accepted byte, check each accepted result word
   always @(posedge clock) begin : watch_ports
      rsp_word_t want;
      rsp_word_t seen;
      logic      yields;
      byte_accepted = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            byte_accepted = 1'b1;
            accepted_count++;
            yields = parse_file_byte(req_byte_value, req_start_of_file, want);
            if (yields) awaited_words.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_payload_byte, rsp_payload_valid, rsp_done_res, rsp_status,
                    rsp_data_length, rsp_duration_ms, rsp_format_tag, rsp_channel_count,
                    rsp_sample_rate, rsp_byte_rate, rsp_block_align, rsp_bits_per_sample};
            if (awaited_words.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t ns unexpected word: expected none, actual payload 0x%0h/%0b done %0b status %0d",
                           $time, seen.payload_byte, seen.payload_valid, seen.done_res,
                           seen.status);
            end else begin
               want = awaited_words.pop_front();
               check_field("payload_byte", want.payload_byte, seen.payload_byte);
               check_field("payload_valid", want.payload_valid, seen.payload_valid);
               check_field("done_res", want.done_res, seen.done_res);
               check_field("status", want.status, seen.status);
               check_field("data_length", want.data_length, seen.data_length);
               check_field("duration_ms", want.duration_ms, seen.duration_ms);
               check_field("format_tag", want.format_tag, seen.format_tag);
               check_field("channel_count", want.channel_count, seen.channel_count);
               check_field("sample_rate", want.sample_rate, seen.sample_rate);
               check_field("byte_rate", want.byte_rate, seen.byte_rate);
               check_field("block_align", want.block_align, seen.block_align);
               check_field("bits_per_sample", want.bits_per_sample, seen.bits_per_sample);
               result_words++;
               if (want.payload_valid) payload_words++;
               if (want.done_res) status_seen[want.status]++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Sequencing
   // ---------------------------------------------------------------

   // Hold off until every byte is taken and every word has come, then let the divider settle
   task automatic wait_drained();
      while (accepted_count != queued_count || awaited_words.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_expected_size(input logic [31:0] value);
      csr_valid              <= 1'b1;
      csr_expected_data_size <= value;
      do @(posedge clock); while (!csr_ready);
      size_setting = value;
      size_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timed out after %0d cycles with %0d words outstanding",
               cycle_count, awaited_words.size());
      $display("riff_wave_chunk_parser regression: fail");
      $finish;
   end

   initial begin : run_phases
      logic [7:0]  seq[$];
      logic [31:0] size_now;
      int unsigned phase_start;
      clear_walk();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: bad RIFF magic with extreme byte values, then an empty data
      // chunk with no fmt under the reset size (zero byte rate)
      seq = {8'h00, 8'hFF, 8'h49, 8'h46};
      queue_bytes(seq, seq.size());
      seq = {};
      put_word(seq, ID_RIFF);
      put_word(seq, 32'd12);
      put_word(seq, ID_WAVE);
      put_word(seq, ID_DATA);
      put_word(seq, 32'd0);
      queue_bytes(seq, seq.size());
      wait_drained();

      // Random phases: each writes its own size setting and sets an idling mix
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0:       size_now = $urandom_range(1, 20);
            1:       size_now = 32'hFFFF_FFFF;
            2:       size_now = '0;
            3:       size_now = $urandom_range(21, 48);
            4:       size_now = 32'd1;
            default: size_now = $urandom_range(2, 16);
         endcase
         send_idle_pct = (ph < 2) ? 26 : (ph < 4) ? 69 : 0;
         recv_idle_pct = (ph < 2) ? 69 : (ph < 4) ? 26 : 0;
         write_expected_size(size_now);
         // back up the result side while bytes keep coming
         if (ph == 4) begin
            @(posedge clock);
            hold_left = HOLD_CYCLES;
         end
         phase_start = queued_count;
         while (queued_count - phase_start < PHASE_BYTES) begin
            if ($urandom_range(0, 9) == 0) queue_noise();
            queue_wave_file(size_now);
         end
         wait_drained();
      end

      $display("Streamed %0d file bytes under %0d size settings; checked %0d words (%0d data bytes)",
               accepted_count, size_writes + 1, result_words, payload_words);
      $display("File results ok/riff/wave/fact/size/nodata/rate: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
               status_seen[ST_OK], status_seen[ST_NOT_RIFF], status_seen[ST_NOT_WAVE],
               status_seen[ST_COMPRESS], status_seen[ST_SIZE_BAD], status_seen[ST_NO_DATA],
               status_seen[ST_ZERO_RATE]);
      if (error_count == 0) begin
         $display("riff_wave_chunk_parser regression: pass");
      end else begin
         $display("riff_wave_chunk_parser regression: fail");
      end
      $finish;
   end

endmodule
